@@ src/bmrq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmrq_pkg
// Shared types and constants of the bounded message ring queue.
// ----------------------------------------------------------------------------
package bmrq_pkg;

	localparam int SLOTS_DEF         = 16;
	localparam int PAYLOAD_BYTES_DEF = 64;

	// most results one dequeue transaction may produce
	localparam int RESULT_CAP = 64;
	localparam int LIMIT_W    = 7;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic               operation;
		logic [15:0]        msg_tag;
		logic [7:0]         data_byte;
		logic               byte_valid;
		logic               last_byte;
		logic [LIMIT_W-1:0] read_limit;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [15:0]        out_msg_tag;
		logic [7:0]         out_byte;
		logic               out_byte_valid;
		logic [LIMIT_W-1:0] delivered_length;
		logic               last_result;
	} result_t;

endpackage
`default_nettype wire

@@ src/bmrq_payload_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmrq_payload_ram
// Payload byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bmrq_payload_ram #(
	parameter int AW = 10
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ src/bmrq_slot_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmrq_slot_ram
// Per-slot message id and length store. Id and length are written
// independently; one registered read returns both.
// ----------------------------------------------------------------------------
module bmrq_slot_ram #(
	parameter int SLOTS  = 16,
	parameter int SLOT_W = 4,
	parameter int LEN_W  = 7
) (
	input  wire logic              clk,
	input  wire logic              id_we,
	input  wire logic [SLOT_W-1:0] id_waddr,
	input  wire logic [15:0]       id_wdata,
	input  wire logic              len_we,
	input  wire logic [SLOT_W-1:0] len_waddr,
	input  wire logic [LEN_W-1:0]  len_wdata,
	input  wire logic              re,
	input  wire logic [SLOT_W-1:0] raddr,
	output logic      [15:0]       id_rdata,
	output logic      [LEN_W-1:0]  len_rdata
);

	logic [15:0]      id_mem  [SLOTS];
	logic [LEN_W-1:0] len_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (id_we) begin
			id_mem[id_waddr] <= id_wdata;
		end
		if (len_we) begin
			len_mem[len_waddr] <= len_wdata;
		end
		if (re) begin
			id_rdata  <= id_mem[raddr];
			len_rdata <= len_mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ src/bounded_message_ring_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_message_ring_queue
// Ring of message slots, filled a byte at a time and drained a message at a
// time.
// ----------------------------------------------------------------------------
// Input channel (item_*): an enqueue transaction carries at most one message
// byte; the first item of a message fixes its id and the one with last_byte
// set commits the slot. A message that opens on a full ring is rejected whole.
// A dequeue transaction takes the oldest committed message.
// Output channel (result_*): one result per enqueue transaction (status ok
// or full), and per dequeue either one result (empty queue, empty message or
// zero read limit) or one result per delivered byte, the last one marked.
// Enqueue: result in the cycle after acceptance; one transaction per cycle
// while the output register is free. Dequeue: empty result in the cycle
// after acceptance; otherwise the slot memory read, the payload memory read
// and the output register lie between acceptance and the first byte, and the
// rest follow one per cycle while the receiver takes them. The next
// transaction is taken once the last byte has moved into the output register.
// A stalled receiver holds the output register and pauses the payload read
// stream; no result is lost. Reset empties the ring and drops any open
// message; the memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module bounded_message_ring_queue #(
	parameter int SLOTS         = bmrq_pkg::SLOTS_DEF,
	parameter int PAYLOAD_BYTES = bmrq_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire bmrq_pkg::item_t  item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output bmrq_pkg::result_t     result
);

	import bmrq_pkg::*;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PTR_W  = $clog2(2 * SLOTS);
	localparam int OCC_W  = PTR_W + 1;
	localparam int LEN_W  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES + 1) : 1;
	localparam int IDX_W  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int CMP_W  = (LEN_W > LIMIT_W) ? LEN_W : LIMIT_W;
	localparam int AW     = SLOT_W + IDX_W;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_META   = 2'd1;
	localparam logic [1:0] S_STREAM = 2'd2;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
		if (p >= PTR_W'(SLOTS)) begin
			return SLOT_W'(p - PTR_W'(SLOTS));
		end
		return SLOT_W'(p);
	endfunction

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(2 * SLOTS - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	logic [1:0]         state_q;
	logic [PTR_W-1:0]   wp_q, rp_q;
	logic               open_q, rej_q;
	logic [LEN_W-1:0]   bt_q;
	logic               pend_s1;
	logic [LIMIT_W-1:0] rd_idx_q, out_cnt_q;
	logic               result_valid_q;
	result_t            result_q;

	logic [SLOT_W-1:0]  rs_q;
	logic [LIMIT_W-1:0] limit_q, len_q;
	logic [15:0]        id_q;

	logic               out_free, accept, enq_acc, deq_acc;
	logic [OCC_W-1:0]   occ;
	logic               full, empty;
	logic [SLOT_W-1:0]  ws, rs;
	logic               rej_now, byte_ok;
	logic [LEN_W-1:0]   bt_cur, bt_new;

	logic [15:0]        slot_id;
	logic [LEN_W-1:0]   slot_len;
	logic [LIMIT_W-1:0] lim_cap, meta_len;
	logic               meta_zero_load, meta_issue;

	logic [7:0]         pay_rdata;
	logic               pay_re;
	logic [LIMIT_W-1:0] rd_idx_sel;
	logic               byte_load, byte_last, stream_issue;

	logic               load_en;
	result_t            load_data;

	assign out_free   = !result_valid_q || result_ready;
	assign item_ready = (state_q == S_IDLE) && out_free;
	assign accept     = item_valid && item_ready;
	assign enq_acc    = accept && (item.operation == OP_ENQ);
	assign deq_acc    = accept && (item.operation == OP_DEQ);

	always_comb begin
		if (wp_q >= rp_q) begin
			occ = OCC_W'(wp_q) - OCC_W'(rp_q);
		end else begin
			occ = OCC_W'(wp_q) + OCC_W'(2 * SLOTS) - OCC_W'(rp_q);
		end
	end

	assign full  = (occ >= OCC_W'(SLOTS));
	assign empty = (wp_q == rp_q);
	assign ws    = slot_of(wp_q);
	assign rs    = slot_of(rp_q);

	// fullness is judged only when a message opens
	assign rej_now = open_q ? rej_q : full;
	assign bt_cur  = open_q ? bt_q : '0;
	assign byte_ok = !rej_now && item.byte_valid && (bt_cur < LEN_W'(PAYLOAD_BYTES));
	assign bt_new  = byte_ok ? bt_cur + LEN_W'(1) : bt_cur;

	// delivered length = min(stored length, read limit, result cap)
	assign lim_cap  = (limit_q > LIMIT_W'(RESULT_CAP)) ? LIMIT_W'(RESULT_CAP) : limit_q;
	assign meta_len = (CMP_W'(slot_len) < CMP_W'(lim_cap)) ? LIMIT_W'(slot_len) : lim_cap;
	assign meta_zero_load = (state_q == S_META) && (meta_len == '0) && out_free;
	assign meta_issue     = (state_q == S_META) && (meta_len != '0);

	// payload read stream: pend_s1 marks a byte waiting at the RAM output
	assign byte_load    = (state_q == S_STREAM) && pend_s1 && out_free;
	assign byte_last    = (out_cnt_q + LIMIT_W'(1) == len_q);
	assign stream_issue = (state_q == S_STREAM) && (rd_idx_q < len_q)
		&& (!pend_s1 || byte_load);
	assign pay_re       = meta_issue || stream_issue;
	assign rd_idx_sel   = (state_q == S_META) ? '0 : rd_idx_q;

	// Memory writes only happen on enqueue transactions taken in idle, reads only
	// on dequeue acceptance or in the dequeue states, so no access to an entry overlaps.
	bmrq_payload_ram #(
		.AW(AW)
	) u_payload (
		.clk   (clk),
		.we    (enq_acc && byte_ok),
		.waddr ({ws, IDX_W'(bt_cur)}),
		.wdata (item.data_byte),
		.re    (pay_re),
		.raddr ({rs_q, IDX_W'(rd_idx_sel)}),
		.rdata (pay_rdata)
	);

	bmrq_slot_ram #(
		.SLOTS  (SLOTS),
		.SLOT_W (SLOT_W),
		.LEN_W  (LEN_W)
	) u_slot (
		.clk       (clk),
		.id_we     (enq_acc && !open_q && !full),
		.id_waddr  (ws),
		.id_wdata  (item.msg_tag),
		.len_we    (enq_acc && item.last_byte && !rej_now),
		.len_waddr (ws),
		.len_wdata (bt_new),
		.re        (deq_acc && !empty),
		.raddr     (rs),
		.id_rdata  (slot_id),
		.len_rdata (slot_len)
	);

	always_comb begin
		load_en   = 1'b0;
		load_data = '0;
		if (enq_acc) begin
			load_en               = 1'b1;
			load_data.status      = rej_now ? ST_FULL : ST_OK;
			load_data.last_result = 1'b1;
		end else if (deq_acc && empty) begin
			load_en               = 1'b1;
			load_data.status      = ST_EMPTY;
			load_data.last_result = 1'b1;
		end else if (meta_zero_load) begin
			load_en               = 1'b1;
			load_data.status      = ST_OK;
			load_data.out_msg_tag = slot_id;
			load_data.last_result = 1'b1;
		end else if (byte_load) begin
			load_en                    = 1'b1;
			load_data.status           = ST_OK;
			load_data.out_msg_tag      = id_q;
			load_data.out_byte         = pay_rdata;
			load_data.out_byte_valid   = 1'b1;
			load_data.delivered_length = len_q;
			load_data.last_result      = byte_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			wp_q           <= '0;
			rp_q           <= '0;
			open_q         <= 1'b0;
			rej_q          <= 1'b0;
			bt_q           <= '0;
			pend_s1        <= 1'b0;
			rd_idx_q       <= '0;
			out_cnt_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (load_en) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			if (enq_acc) begin
				if (item.last_byte) begin
					if (!rej_now) begin
						wp_q <= advance(wp_q);
					end
					open_q <= 1'b0;
					rej_q  <= 1'b0;
					bt_q   <= '0;
				end else begin
					open_q <= 1'b1;
					rej_q  <= rej_now;
					bt_q   <= bt_new;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (deq_acc && !empty) begin
						rp_q    <= advance(rp_q);
						state_q <= S_META;
					end
				end
				S_META: begin
					if (meta_issue) begin
						rd_idx_q  <= LIMIT_W'(1);
						out_cnt_q <= '0;
						pend_s1   <= 1'b1;
						state_q   <= S_STREAM;
					end else if (meta_zero_load) begin
						state_q <= S_IDLE;
					end
				end
				S_STREAM: begin
					if (stream_issue) begin
						rd_idx_q <= rd_idx_q + LIMIT_W'(1);
						pend_s1  <= 1'b1;
					end else if (byte_load) begin
						pend_s1 <= 1'b0;
					end
					if (byte_load) begin
						out_cnt_q <= out_cnt_q + LIMIT_W'(1);
						if (byte_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			result_q <= load_data;
		end
		if (deq_acc) begin
			rs_q    <= rs;
			limit_q <= item.read_limit;
		end
		if (meta_issue) begin
			len_q <= meta_len;
			id_q  <= slot_id;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= OCC_W'(SLOTS))
		else $error("ring occupancy above slot count");

	a_rej_open: assert property (@(posedge clk) disable iff (!arst_n)
		rej_q |-> open_q)
		else $error("rejected flag without an open message");

	a_pend_state: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == S_STREAM))
		else $error("pending payload byte outside the read stream");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STREAM) |-> (rd_idx_q <= len_q) && (out_cnt_q < len_q))
		else $error("read stream index past delivered length");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_load && byte_last) |=> (state_q == S_IDLE) && result_valid)
		else $error("stream did not end after its last byte");

endmodule
`default_nettype wire

@@ verif/bounded_message_ring_queue_checker.sv @@
// ----------------------------------------------------------------------------
// bounded_message_ring_queue_checker
// Watches both channels of the message ring queue. It keeps its own copy of
// the ring, works out the results owed for each accepted transaction, and
// compares every result field by field against the oldest one owed.
// ----------------------------------------------------------------------------
module bounded_message_ring_queue_checker
	import bmrq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_ready,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result,
	output int      mismatches,
	output int      outstanding,
	output int      results_checked
);

	localparam int NSLOTS   = SLOTS_DEF;
	localparam int SLOT_CAP = PAYLOAD_BYTES_DEF;
	localparam int PTR_MOD  = 2 * NSLOTS;

	logic [7:0]         ring_bytes [NSLOTS][SLOT_CAP];
	logic [15:0]        ring_ids   [NSLOTS];
	logic [LIMIT_W-1:0] ring_lens  [NSLOTS];

	// pointers count modulo twice the slot count, upper half is the wrap bit
	int wr_ptr = 0;
	int rd_ptr = 0;
	int bytes_in = 0;
	bit msg_open = 1'b0;
	bit msg_rejected = 1'b0;

	result_t owed_results [$];
	int error_count = 0;
	int owed_count = 0;
	int seen_count = 0;

	assign mismatches      = error_count;
	assign outstanding     = owed_count;
	assign results_checked = seen_count;

	task automatic flag_error(input string msg);
		error_count++;
		$display("[%0t] ERROR: %s", $time, msg);
	endtask

	task automatic apply_ring_item(input item_t it);
		result_t r;
		int slot;
		int fill;
		int n;
		r = '0;
		r.last_result = 1'b1;
		fill = (wr_ptr - rd_ptr + PTR_MOD) % PTR_MOD;
		if (it.operation == OP_ENQ) begin
			slot = wr_ptr % NSLOTS;
			// fullness only counts when a message opens
			if (!msg_open) begin
				msg_open = 1'b1;
				bytes_in = 0;
				msg_rejected = (fill >= NSLOTS);
				if (!msg_rejected)
					ring_ids[slot] = it.msg_tag;
			end
			if (!msg_rejected && it.byte_valid && bytes_in < SLOT_CAP) begin
				ring_bytes[slot][bytes_in] = it.data_byte;
				bytes_in++;
			end
			r.status = msg_rejected ? ST_FULL : ST_OK;
			if (it.last_byte) begin
				if (!msg_rejected) begin
					ring_lens[slot] = LIMIT_W'(bytes_in);
					wr_ptr = (wr_ptr + 1) % PTR_MOD;
				end
				msg_open = 1'b0;
				msg_rejected = 1'b0;
				bytes_in = 0;
			end
			owed_results.push_back(r);
		end else if (fill == 0) begin
			r.status = ST_EMPTY;
			owed_results.push_back(r);
		end else begin
			slot = rd_ptr % NSLOTS;
			n = ring_lens[slot];
			if (n > it.read_limit)
				n = it.read_limit;
			if (n > RESULT_CAP)
				n = RESULT_CAP;
			rd_ptr = (rd_ptr + 1) % PTR_MOD;
			r.status = ST_OK;
			r.out_msg_tag = ring_ids[slot];
			if (n == 0)
				owed_results.push_back(r);
			for (int i = 0; i < n; i++) begin
				r.out_byte = ring_bytes[slot][i];
				r.out_byte_valid = 1'b1;
				r.delivered_length = LIMIT_W'(n);
				r.last_result = (i == n - 1);
				owed_results.push_back(r);
			end
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		seen_count++;
		if (owed_results.size() == 0) begin
			flag_error($sformatf("unexpected result: status %0d id %h byte %h last %0b",
				got.status, got.out_msg_tag, got.out_byte, got.last_result));
			return;
		end
		want = owed_results.pop_front();
		if (got.status !== want.status)
			flag_error($sformatf("status %0d, expected %0d", got.status, want.status));
		if (got.out_msg_tag !== want.out_msg_tag)
			flag_error($sformatf("out_msg_tag %h, expected %h",
				got.out_msg_tag, want.out_msg_tag));
		if (got.out_byte !== want.out_byte)
			flag_error($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
		if (got.out_byte_valid !== want.out_byte_valid)
			flag_error($sformatf("out_byte_valid %0b, expected %0b",
				got.out_byte_valid, want.out_byte_valid));
		if (got.delivered_length !== want.delivered_length)
			flag_error($sformatf("delivered_length %0d, expected %0d",
				got.delivered_length, want.delivered_length));
		if (got.last_result !== want.last_result)
			flag_error($sformatf("last_result %0b, expected %0b",
				got.last_result, want.last_result));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr = 0;
			rd_ptr = 0;
			bytes_in = 0;
			msg_open = 1'b0;
			msg_rejected = 1'b0;
			owed_results.delete();
		end else begin
			if (result_valid && result_ready)
				check_result(result);
			if (item_valid && item_ready)
				apply_ring_item(item);
		end
		owed_count = owed_results.size();
	end

endmodule

@@ verif/bounded_message_ring_queue_test.sv @@
// ----------------------------------------------------------------------------
// bounded_message_ring_queue_test
// Drives enqueue and dequeue transactions into the message ring queue: a
// directed opening, then random messages, dequeues, ring fills and drains,
// with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module bounded_message_ring_queue_test;
	import bmrq_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int ITEM_TARGET = 370;
	localparam int NSLOTS      = SLOTS_DEF;
	localparam int HOLD_CYCLES = 200;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	int mismatches;
	int outstanding;
	int results_checked;

	int items_sent = 0;
	int enq_sent = 0;
	int deq_sent = 0;
	int stall_cycles = 0;
	bit calm = 1'b0;
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;

	always #2 clk = ~clk;

	bounded_message_ring_queue i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	bounded_message_ring_queue_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.item            (item),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result          (result),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	// nothing accepted on either side for too long means a hang
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[%0t] watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : receiver
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				result_ready <= calm || ($urandom_range(99) >= 15);
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input item_t it);
		while (!calm && $urandom_range(99) < 15) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [15:0] id, input logic [7:0] data,
		input logic has_byte, input logic last);
		item_t it;
		it = '0;
		it.operation = OP_ENQ;
		it.msg_tag = id;
		it.data_byte = data;
		it.byte_valid = has_byte;
		it.last_byte = last;
		it.read_limit = LIMIT_W'($urandom);
		send_item(it);
		enq_sent++;
	endtask

	task automatic send_dequeue(input int limit);
		item_t it;
		it = '0;
		it.operation = OP_DEQ;
		it.msg_tag = 16'($urandom);
		it.data_byte = 8'($urandom);
		it.byte_valid = 1'($urandom);
		it.last_byte = 1'($urandom);
		it.read_limit = LIMIT_W'(limit);
		send_item(it);
		deq_sent++;
	endtask

	function automatic int pick_read_limit();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 0;
		if (r < 20)
			return $urandom_range(65, 127);
		if (r < 40)
			return RESULT_CAP;
		return $urandom_range(1, RESULT_CAP - 1);
	endfunction

	// nbytes of zero sends a single item that carries no byte
	task automatic send_message(input logic [15:0] id, input int nbytes, input int deq_pct);
		int n;
		n = (nbytes == 0) ? 1 : nbytes;
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(99) < deq_pct)
				send_dequeue(pick_read_limit());
			send_byte((i == 0) ? id : 16'($urandom), 8'($urandom),
				(nbytes != 0) && ($urandom_range(99) < 92), i == n - 1);
		end
	endtask

	// overfill the ring; the last message opens on a full ring and must stay
	// rejected even though dequeues free slots while it is open
	task automatic fill_ring();
		repeat (NSLOTS + 2)
			send_message(16'($urandom), $urandom_range(0, 2), 0);
		send_message(16'($urandom), 3, 100);
	endtask

	task automatic wait_for_drain();
		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
	endtask

	initial begin : stimulus
		int pick;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed opening
		send_dequeue(RESULT_CAP);                   // empty queue
		send_byte(16'hFFFF, 8'h00, 1'b0, 1'b1);     // message with no bytes
		send_dequeue(RESULT_CAP);
		send_byte(16'h0000, 8'hFF, 1'b1, 1'b0);
		send_dequeue(RESULT_CAP);                   // open message is not visible
		send_byte(16'h1234, 8'h00, 1'b1, 1'b0);     // later ids ignored
		send_byte(16'hABCD, 8'hA5, 1'b1, 1'b1);
		send_dequeue(0);                            // zero read limit
		send_byte(16'h8001, 8'h5A, 1'b1, 1'b0);
		send_byte(16'h7FFF, 8'h00, 1'b0, 1'b1);     // closing item without a byte
		send_dequeue(127);                          // limit above the result cap
		send_byte(16'h7FFE, 8'h01, 1'b1, 1'b0);
		send_byte(16'h0001, 8'h80, 1'b1, 1'b0);
		send_byte(16'hFFFE, 8'h7F, 1'b1, 1'b1);
		send_dequeue(1);                            // truncated to one byte
		send_dequeue(RESULT_CAP);
		wait_for_drain();

		// one overlong message, truncated to the slot capacity
		send_message(16'($urandom),
			$urandom_range(PAYLOAD_BYTES_DEF + 16, PAYLOAD_BYTES_DEF + 32), 0);

		while (items_sent < ITEM_TARGET) begin
			calm = (items_sent >= 200 && items_sent < 280);
			if (!hold_done && items_sent >= 120) begin
				hold_done = 1'b1;
				hold_request = 1'b1;
				fill_ring();
			end else begin
				pick = $urandom_range(99);
				if (pick < 47)
					send_message(16'($urandom),
						($urandom_range(99) < 80) ? $urandom_range(0, 6)
						: $urandom_range(7, 24), 10);
				else if (pick < 90)
					send_dequeue(pick_read_limit());
				else if (pick < 95)
					fill_ring();
				else begin
					wait_for_drain();
					repeat (NSLOTS + 1)
						send_dequeue(pick_read_limit());
				end
			end
		end
		calm = 1'b0;

		wait_for_drain();
		repeat (20) @(negedge clk);
		$display("Ran %0d transactions: %0d enqueue bytes and %0d dequeues, %0d results checked.",
			items_sent, enq_sent, deq_sent, results_checked);
		$display("Covered empty reads, empty and overlong messages, full-ring rejection and truncation.");
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
